@@ rtl/hcmma_pkg.sv @@
// Shared types, constants and codes for the heightfield chunk statistics block.
package hcmma_pkg;

    // Default geometry of the height store
    localparam int MAX_SIDE_LOG2_DEF = 8;
    localparam int PIXEL_BITS_DEF    = 16;

    // Configuration register indexes and reset values
    localparam int        CFG_IDX_W      = 1;
    localparam int        CFG_DATA_W     = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LOG2  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LOG2 = 1'd1;
    localparam logic [CFG_DATA_W-1:0] SIDE_LOG2_RST  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] CHUNK_LOG2_RST = 4'd5;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [1:0] ST_BAD_CHUNK = 2'd2;

    // Request modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Request payload
    typedef struct packed {
        logic        mode;
        logic [7:0]  pixel_col;
        logic [7:0]  pixel_row;
        logic [15:0] pixel_value;
        logic [3:0]  query_level;
        logic [7:0]  query_cx;
        logic [7:0]  query_cy;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [15:0] height_min;
        logic [15:0] height_max;
        logic [15:0] avg_height;
        logic [15:0] corner_00;
        logic [15:0] corner_10;
        logic [15:0] corner_01;
        logic [15:0] corner_11;
        logic [1:0]  status;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic wr;     // store one pixel from the request
        logic load;   // capture query fields
        logic check;  // range check, set up walk, clear accumulators
        logic walk;   // issue one pixel read and advance
        logic fin;    // form and present the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic err;    // query out of range
        logic last;   // current read is the last pixel of the chunk
    } t_sts;

endpackage

@@ rtl/hcmma_ram.sv @@
// Generic simple dual-port RAM with registered read.
module hcmma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hcmma_ctrl.sv @@
// Sequencer for pixel writes and chunk query walks.
module hcmma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_mode,
    input  hcmma_pkg::t_sts  i_sts,
    output hcmma_pkg::t_cmd  o_cmd,
    output logic             busy
);

    import hcmma_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign accept = start && (r_state == S_IDLE);

    // Decode commands from state
    always_comb begin
        o_cmd       = '0;
        o_cmd.wr    = accept && (i_mode == MODE_WRITE);
        o_cmd.load  = accept && (i_mode == MODE_QUERY);
        o_cmd.check = (r_state == S_CHECK);
        o_cmd.walk  = (r_state == S_WALK);
        o_cmd.fin   = (r_state == S_FINAL);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == MODE_QUERY)) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.err ? S_FINAL : S_WALK;
            end
            S_WALK: begin
                if (i_sts.last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_FINAL;
            end
            S_FINAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    // A query request always goes to the range check next
    a_load_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHECK))
        else $error("query request did not enter range check");

    // The drain cycle only follows the walk
    a_drain_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> ($past(r_state) == S_WALK))
        else $error("drain entered without a walk");

    // No pixel write while a query is in flight
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> !busy)
        else $error("pixel write while busy");

endmodule

@@ rtl/hcmma_dp.sv @@
// Datapath: height store, config registers, chunk walk and statistics.
module hcmma_dp #(
    parameter int MAX_SIDE_LOG2 = hcmma_pkg::MAX_SIDE_LOG2_DEF,
    parameter int PIXEL_BITS    = hcmma_pkg::PIXEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hcmma_pkg::t_req                     i_req,
    input  hcmma_pkg::t_cmd                     i_cmd,
    output hcmma_pkg::t_sts                     o_sts,
    input  logic                                i_cfg_we,
    input  logic [hcmma_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hcmma_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                o_done,
    output hcmma_pkg::t_rsp                     o_rsp
);

    import hcmma_pkg::*;

    localparam int M     = MAX_SIDE_LOG2;
    localparam int P     = PIXEL_BITS;
    localparam int AW    = 2 * M;
    localparam int DEPTH = 1 << AW;
    localparam int SUMW  = 2 * M + P;

    // Configuration registers
    logic [3:0] r_side_log2;
    logic [3:0] r_chunk_log2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_log2  <= SIDE_LOG2_RST;
            r_chunk_log2 <= CHUNK_LOG2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIDE_LOG2:  r_side_log2  <= i_cfg_wdata;
                CFG_CHUNK_LOG2: r_chunk_log2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp side and chunk sizes
    logic [3:0]   s_eff;
    logic [3:0]   c_eff;
    logic [M-1:0] side_mask;

    always_comb begin
        if (r_side_log2 < 4'd1) begin
            s_eff = 4'd1;
        end else if (r_side_log2 > 4'(M)) begin
            s_eff = 4'(M);
        end else begin
            s_eff = r_side_log2;
        end
        c_eff     = (r_chunk_log2 > s_eff) ? s_eff : r_chunk_log2;
        side_mask = ~({M{1'b1}} << s_eff);
    end

    // Pixel write: drop out-of-image writes, mirror the row
    logic          wr_en;
    logic [M-1:0]  wr_row;
    logic [M-1:0]  wr_col;
    logic [AW-1:0] wr_addr;
    logic [P-1:0]  wr_data;

    assign wr_en   = i_cmd.wr && ((i_req.pixel_col >> s_eff) == 8'd0)
                              && ((i_req.pixel_row >> s_eff) == 8'd0);
    assign wr_row  = ~M'(i_req.pixel_row) & side_mask;
    assign wr_col  = M'(i_req.pixel_col);
    assign wr_addr = {wr_row, wr_col};
    assign wr_data = P'(i_req.pixel_value);

    // Captured query fields
    logic [3:0] r_lvl;
    logic [7:0] r_cx;
    logic [7:0] r_cy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lvl <= i_req.query_level;
            r_cx  <= i_req.query_cx;
            r_cy  <= i_req.query_cy;
        end
    end

    // Range check on the captured query
    logic       bad_lvl;
    logic       bad_chunk;
    logic [3:0] clog;

    assign bad_lvl   = (r_lvl > (s_eff - c_eff));
    assign bad_chunk = ((r_cx >> r_lvl) != 8'd0) || ((r_cy >> r_lvl) != 8'd0);
    assign clog      = s_eff - r_lvl;

    // Walk registers
    logic [1:0]    r_status;
    logic [3:0]    r_clog;
    logic [M-1:0]  r_cmask;
    logic [M-1:0]  r_x0;
    logic [M-1:0]  r_y0;
    logic [M-1:0]  r_ox;
    logic [M-1:0]  r_oy;
    logic          ox_end;
    logic          oy_end;
    logic [AW-1:0] rd_addr;
    logic [3:0]    tag;

    assign ox_end  = (r_ox == r_cmask);
    assign oy_end  = (r_oy == r_cmask);
    assign rd_addr = {r_y0 | r_oy, r_x0 | r_ox};
    // Corner flags: 00, 10, 01, 11
    assign tag = {ox_end && oy_end, (r_ox == '0) && oy_end,
                  ox_end && (r_oy == '0), (r_ox == '0) && (r_oy == '0)};

    assign o_sts.err  = bad_lvl || bad_chunk;
    assign o_sts.last = ox_end && oy_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            if (bad_lvl) begin
                r_status <= ST_BAD_LEVEL;
            end else if (bad_chunk) begin
                r_status <= ST_BAD_CHUNK;
            end else begin
                r_status <= ST_OK;
            end
            r_clog  <= clog;
            r_cmask <= ~({M{1'b1}} << clog);
            r_x0    <= M'(r_cx) << clog;
            r_y0    <= M'(r_cy) << clog;
            r_ox    <= '0;
            r_oy    <= '0;
        end else if (i_cmd.walk) begin
            // Advance raster position inside the chunk
            if (ox_end) begin
                r_ox <= '0;
                r_oy <= r_oy + M'(1);
            end else begin
                r_ox <= r_ox + M'(1);
            end
        end
    end

    // Height store
    logic [P-1:0] rd_data;

    hcmma_ram #(
        .WIDTH (P),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Read data is valid in the cycle after the address
    logic       r_vld;
    logic [3:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_cmd.walk;
        end
        r_tag <= tag;
    end

    // Accumulate statistics and capture corners
    logic [P-1:0]    r_min;
    logic [P-1:0]    r_max;
    logic [SUMW-1:0] r_sum;
    logic [P-1:0]    r_c00;
    logic [P-1:0]    r_c10;
    logic [P-1:0]    r_c01;
    logic [P-1:0]    r_c11;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_min <= {P{1'b1}};
            r_max <= '0;
            r_sum <= '0;
        end else if (r_vld) begin
            if (rd_data < r_min) r_min <= rd_data;
            if (rd_data > r_max) r_max <= rd_data;
            r_sum <= r_sum + SUMW'(rd_data);
            if (r_tag[0]) r_c00 <= rd_data;
            if (r_tag[1]) r_c10 <= rd_data;
            if (r_tag[2]) r_c01 <= rd_data;
            if (r_tag[3]) r_c11 <= rd_data;
        end
    end

    // Form the result
    logic [4:0]  shamt;
    logic [15:0] avg;
    t_rsp        n_rsp;
    t_rsp        r_rsp;
    logic        r_done;

    assign shamt = {r_clog, 1'b0};
    assign avg   = 16'(r_sum >> shamt);

    always_comb begin
        n_rsp        = '0;
        n_rsp.status = r_status;
        if (r_status == ST_OK) begin
            n_rsp.height_min = 16'(r_min);
            n_rsp.height_max = 16'(r_max);
            n_rsp.avg_height = avg;
            n_rsp.corner_00  = 16'(r_c00);
            n_rsp.corner_10  = 16'(r_c10);
            n_rsp.corner_01  = 16'(r_c01);
            n_rsp.corner_11  = 16'(r_c11);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.fin;
        end
        if (i_cmd.fin) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held more than one cycle");

    // Error results carry no statistics
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_rsp.status != ST_OK)) |->
            (r_rsp.height_min == 16'd0) && (r_rsp.height_max == 16'd0) &&
            (r_rsp.avg_height == 16'd0) && (r_rsp.corner_11 == 16'd0))
        else $error("error result with nonzero fields");

    // Mean lies between minimum and maximum
    a_avg_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_rsp.status == ST_OK)) |->
            (r_rsp.height_min <= r_rsp.avg_height) &&
            (r_rsp.avg_height <= r_rsp.height_max))
        else $error("mean outside min/max");

endmodule

@@ rtl/heightfield_chunk_minmax_avg.sv @@
// Top level: heightfield store with min/max/mean chunk queries.
//
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    i_req  (hcmma_pkg::t_req)
// result    out        o_done one-cycle strobe o_rsp  (hcmma_pkg::t_rsp)
// config    in         i_cfg_we                i_cfg_idx, i_cfg_wdata
//
// A pixel write is accepted whenever busy is low; writes can be issued
// every cycle while no query is in flight. A query of a chunk of side 2^c
// walks the chunk through the single read port of the height store, which
// returns one pixel a cycle, then drains; a rejected query skips the walk.
// Synchronous active-low reset restores config registers; the store is
// not cleared. The result cannot be stalled: o_done is high for one cycle.
module heightfield_chunk_minmax_avg #(
    parameter int MAX_SIDE_LOG2 = hcmma_pkg::MAX_SIDE_LOG2_DEF,
    parameter int PIXEL_BITS    = hcmma_pkg::PIXEL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  hcmma_pkg::t_req                  i_req,
    output logic                             busy,
    output logic                             o_done,
    output hcmma_pkg::t_rsp                  o_rsp,
    input  logic                             i_cfg_we,
    input  logic [hcmma_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hcmma_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import hcmma_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    hcmma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_req.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Store and statistics
    hcmma_dp #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule
